// ----- src/mktx_pkg.sv -----
// Shared constants, types and codes of the k-transaction profit block.
package mktx_pkg;

  // Capacity of the cell chain and the day counter
  localparam int unsigned MAX_TRANS = 16;
  localparam int unsigned DAY_CAP   = 65536;

  // Field and state widths
  localparam int unsigned PRICE_W  = 31;
  localparam int unsigned PROFIT_W = 47;
  localparam int unsigned VAL_W    = 48;
  localparam int unsigned K_W      = 10;
  localparam int unsigned DAY_W    = $clog2(DAY_CAP) + 1;
  localparam int unsigned IDX_W    = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
  localparam int unsigned CMP_W    = (DAY_W > K_W) ? DAY_W : K_W;

  // Reset values
  localparam logic [VAL_W-1:0]    HOLD_FLOOR = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [PROFIT_W-1:0] PROFIT_TOP = {PROFIT_W{1'b1}};
  localparam logic [K_W-1:0]      K_RESET    = K_W'(1);

  // Control handed down the cell chain
  typedef struct packed {
    logic step;   // apply one price to every cell
    logic clear;  // return every cell to its series start
  } ctrl_t;

  // Sequencer states
  typedef enum logic [0:0] {
    ST_RUN,
    ST_FINISH
  } state_e;

endpackage

// ----- src/mktx_in_if.sv -----
// Price input channel: valid/ready with one daily price per transaction.
interface mktx_in_if;
  logic                          valid;
  logic                          ready;
  logic [mktx_pkg::PRICE_W-1:0]  price;
  logic                          last_day;

  modport source (output valid, output price, output last_day, input ready);
  modport sink (input valid, input price, input last_day, output ready);
endinterface

// ----- src/mktx_out_if.sv -----
// Result output channel: valid/ready with the profit of one series.
interface mktx_out_if;
  logic                          valid;
  logic                          ready;
  logic [mktx_pkg::PROFIT_W-1:0] best_profit;
  logic                          limit_exceeded;

  modport source (output valid, output best_profit, output limit_exceeded, input ready);
  modport sink (input valid, input best_profit, input limit_exceeded, output ready);
endinterface

// ----- src/mktx_cell.sv -----
// One cell of the chain: best holding and best after-sale value for one count.
module mktx_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mktx_pkg::ctrl_t               ctrl_i,
  input  logic [mktx_pkg::PRICE_W-1:0]  price_i,
  input  logic [mktx_pkg::PROFIT_W-1:0] prior_i,
  output logic [mktx_pkg::PROFIT_W-1:0] sale_o
);

  logic [mktx_pkg::VAL_W-1:0]    hold_q, hold_d;
  logic [mktx_pkg::PROFIT_W-1:0] sale_q, sale_d;
  logic [mktx_pkg::VAL_W:0]      sell;
  logic [mktx_pkg::VAL_W-1:0]    buy;

  // Sell today from the held position, or buy today after the neighbor's sale
  always_comb begin
    sell = {hold_q[mktx_pkg::VAL_W-1], hold_q}
         + (mktx_pkg::VAL_W + 1)'(price_i);
    buy  = mktx_pkg::VAL_W'(prior_i) - mktx_pkg::VAL_W'(price_i);
  end

  // Keep the better of old and new values, saturate the sale at the top
  always_comb begin
    sale_d = sale_q;
    hold_d = hold_q;
    if (ctrl_i.clear) begin
      sale_d = '0;
      hold_d = mktx_pkg::HOLD_FLOOR;
    end else if (ctrl_i.step) begin
      if (!sell[mktx_pkg::VAL_W] &&
          (sell[mktx_pkg::VAL_W-1:0] > mktx_pkg::VAL_W'(sale_q))) begin
        sale_d = sell[mktx_pkg::VAL_W-1] ? mktx_pkg::PROFIT_TOP
                                         : sell[mktx_pkg::PROFIT_W-1:0];
      end
      if ($signed(buy) > $signed(hold_q)) begin
        hold_d = buy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sale_q <= '0;
      hold_q <= mktx_pkg::HOLD_FLOOR;
    end else begin
      sale_q <= sale_d;
      hold_q <= hold_d;
    end
  end

  assign sale_o = sale_q;

endmodule

// ----- src/mktx_chain.sv -----
// Row of cells, each fed the after-sale value of its lower neighbor.
module mktx_chain (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  mktx_pkg::ctrl_t                                      ctrl_i,
  input  logic [mktx_pkg::PRICE_W-1:0]                         price_i,
  output logic [mktx_pkg::MAX_TRANS-1:0][mktx_pkg::PROFIT_W-1:0] sale_o
);

  logic [mktx_pkg::MAX_TRANS-1:0][mktx_pkg::PROFIT_W-1:0] prior;

  // The first cell buys from a zero balance
  always_comb begin
    prior[0] = '0;
    for (int unsigned j = 1; j < mktx_pkg::MAX_TRANS; j++) begin
      prior[j] = sale_o[j-1];
    end
  end

  for (genvar g = 0; g < mktx_pkg::MAX_TRANS; g++) begin : g_cell
    mktx_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .price_i (price_i),
      .prior_i (prior[g]),
      .sale_o  (sale_o[g])
    );
  end

endmodule

// ----- src/mktx_rise.sv -----
// Running sum of positive day-to-day rises and the saturating day count.
module mktx_rise (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mktx_pkg::ctrl_t               ctrl_i,
  input  logic [mktx_pkg::PRICE_W-1:0]  price_i,
  output logic [mktx_pkg::PROFIT_W-1:0] rise_sum_o,
  output logic [mktx_pkg::DAY_W-1:0]    day_count_o
);

  logic [mktx_pkg::PRICE_W-1:0]  prev_q, prev_d;
  logic [mktx_pkg::PROFIT_W-1:0] rise_q, rise_d;
  logic [mktx_pkg::DAY_W-1:0]    day_q, day_d;
  logic [mktx_pkg::PROFIT_W:0]   sum;

  // Add today's rise over yesterday, one bit wider to catch overflow
  assign sum = (mktx_pkg::PROFIT_W + 1)'(rise_q)
             + (mktx_pkg::PROFIT_W + 1)'(price_i - prev_q);

  always_comb begin
    prev_d = prev_q;
    rise_d = rise_q;
    day_d  = day_q;
    if (ctrl_i.clear) begin
      prev_d = '0;
      rise_d = '0;
      day_d  = '0;
    end else if (ctrl_i.step) begin
      prev_d = price_i;
      if ((day_q != '0) && (price_i > prev_q)) begin
        rise_d = sum[mktx_pkg::PROFIT_W] ? mktx_pkg::PROFIT_TOP
                                         : sum[mktx_pkg::PROFIT_W-1:0];
      end
      if (day_q != mktx_pkg::DAY_W'(mktx_pkg::DAY_CAP)) begin
        day_d = day_q + mktx_pkg::DAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      rise_q <= '0;
      day_q  <= '0;
    end else begin
      prev_q <= prev_d;
      rise_q <= rise_d;
      day_q  <= day_d;
    end
  end

  assign rise_sum_o  = rise_q;
  assign day_count_o = day_q;

endmodule

// ----- src/max_profit_k_transactions_unit.sv -----
// Top level: best profit from at most k buy-then-sell transactions over a price series.
//
// Prices enter on in_i, one valid/ready transaction per day; last_day marks the
// final price of a series. Each price updates all MAX_TRANS cells of the chain
// at once, so prices of a series are taken back to back, one per cycle.
// After a transaction with last_day set, the block enters a finishing state with
// in_i ready low: it picks the answer (cell k-1, the rise sum, zero or the
// limit-exceeded flag), loads it into the output register and clears the series.
// If out_o still holds an earlier result that the receiver has not taken, the
// finishing state waits, and in_i stays not ready, until that result is taken.
// cfg_we_i writes transaction_limit from cfg_wdata_i; write only while idle.
// Reset sets transaction_limit to 1, clears all series state and drops out_o.valid.
module max_profit_k_transactions_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mktx_pkg::K_W-1:0]   cfg_wdata_i,
  mktx_in_if.sink                    in_i,
  mktx_out_if.source                 out_o
);

  mktx_pkg::state_e                                       state_q, state_d;
  mktx_pkg::ctrl_t                                        ctrl;
  logic [mktx_pkg::K_W-1:0]                               limit_q;
  logic [mktx_pkg::MAX_TRANS-1:0][mktx_pkg::PROFIT_W-1:0] sale;
  logic [mktx_pkg::PROFIT_W-1:0]                          rise_sum;
  logic [mktx_pkg::DAY_W-1:0]                             day_count;
  logic                                                   accept;
  logic                                                   finish;
  logic                                                   out_valid_q, out_valid_d;
  logic [mktx_pkg::PROFIT_W-1:0]                          profit_q, profit_d;
  logic                                                   flag_q, flag_d;
  logic [mktx_pkg::CMP_W-1:0]                             k_ext;
  logic [mktx_pkg::CMP_W-1:0]                             half_ext;
  logic [mktx_pkg::K_W-1:0]                               k_m1;

  // Hold the transaction limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mktx_pkg::K_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mktx_pkg::ST_RUN: begin
        if (accept && in_i.last_day) begin
          state_d = mktx_pkg::ST_FINISH;
        end
      end
      mktx_pkg::ST_FINISH: begin
        if (finish) begin
          state_d = mktx_pkg::ST_RUN;
        end
      end
      default: state_d = mktx_pkg::ST_RUN;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_i.ready = 1'b0;
    finish     = 1'b0;
    case (state_q)
      mktx_pkg::ST_RUN: begin
        in_i.ready = 1'b1;
      end
      mktx_pkg::ST_FINISH: begin
        finish = !out_valid_q || out_o.ready;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  assign accept     = in_i.valid && in_i.ready;
  assign ctrl.step  = accept;
  assign ctrl.clear = finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mktx_pkg::ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  mktx_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .price_i (in_i.price),
    .sale_o  (sale)
  );

  mktx_rise u_rise (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .price_i     (in_i.price),
    .rise_sum_o  (rise_sum),
    .day_count_o (day_count)
  );

  // Pick the answer of the finished series
  assign k_ext    = mktx_pkg::CMP_W'(limit_q);
  assign half_ext = mktx_pkg::CMP_W'(day_count >> 1);
  assign k_m1     = limit_q - mktx_pkg::K_W'(1);

  always_comb begin
    profit_d = '0;
    flag_d   = 1'b0;
    if (limit_q == '0) begin
      profit_d = '0;
    end else if (k_ext >= half_ext) begin
      profit_d = rise_sum;
    end else if (limit_q > mktx_pkg::K_W'(mktx_pkg::MAX_TRANS)) begin
      flag_d = 1'b1;
    end else begin
      profit_d = sale[k_m1[mktx_pkg::IDX_W-1:0]];
    end
  end

  // Load the output register on finish, drop valid once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      profit_q <= profit_d;
      flag_q   <= flag_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.best_profit    = profit_q;
  assign out_o.limit_exceeded = flag_q;

`ifndef NO_ASSERTIONS
  // A last price always leaves the input not ready in the next cycle
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.last_day) |=> !in_i.ready)
    else $error("input ready after last price");

  // A new result only appears out of the finishing state
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == mktx_pkg::ST_FINISH))
    else $error("result without finished series");

  // Clearing returns the first cell to zero
  a_clear_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (sale[0] == '0))
    else $error("cell not cleared after series");

  // A flagged result carries no profit
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && flag_q) |-> (profit_q == '0))
    else $error("profit set with limit exceeded");
`endif

endmodule

// ----- bench/max_profit_k_transactions_unit_test.sv -----
// Self-checking bench for the k-transaction profit block: directed table, wide limit, random.
`timescale 1ns / 1ps

module max_profit_k_transactions_unit_test;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1360;
  localparam int unsigned QUIET_FROM   = 1170;
  localparam int unsigned LONG_DAYS    = 64;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE       = 3;

  localparam logic [mktx_pkg::K_W-1:0]     WIDE_K = 10'd20;
  localparam logic [mktx_pkg::PRICE_W-1:0] PMAX   = {mktx_pkg::PRICE_W{1'b1}};
  localparam longint TOP_VAL   = (longint'(1) << mktx_pkg::PROFIT_W) - 1;
  localparam longint FLOOR_VAL = -(longint'(1) << mktx_pkg::PROFIT_W);

  typedef struct packed {
    logic [mktx_pkg::PROFIT_W-1:0] profit;
    logic                          flag;
  } answer_t;

  // One row of the directed table; typed rows carry their answer
  typedef struct packed {
    logic                          set_k;
    logic [mktx_pkg::K_W-1:0]      k;
    logic [mktx_pkg::PRICE_W-1:0]  price;
    logic                          last;
    logic                          typed;
    logic [mktx_pkg::PROFIT_W-1:0] profit;
    logic                          flag;
  } row_t;

  localparam int unsigned PLAN_LEN = 25;
  localparam row_t PLAN [PLAN_LEN] = '{
    // single day under the reset limit
    '{1'b0, 10'd0,    31'd5,   1'b1, 1'b1, 47'd0, 1'b0},
    // limit 1 reaches half of three days: sum of rises
    '{1'b0, 10'd0,    31'd10,  1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd3,   1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd8,   1'b1, 1'b1, 47'd5, 1'b0},
    // zero limit over extreme prices
    '{1'b1, 10'd0,    PMAX,    1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd0,   1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    PMAX,    1'b1, 1'b1, 47'd0, 1'b0},
    // two transactions out of a saw-tooth, taken from the cell chain
    '{1'b1, 10'd2,    31'd0,   1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    PMAX,    1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd0,   1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    PMAX,    1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd0,   1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    PMAX,    1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd0,   1'b1, 1'b0, 47'd0, 1'b0},
    // largest limit, one full-range rise
    '{1'b1, 10'd1023, 31'd0,   1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    PMAX,    1'b1, 1'b1, {16'd0, PMAX}, 1'b0},
    // limit at capacity covers half of four days
    '{1'b1, 10'd16,   31'd100, 1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd1,   1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd50,  1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd200, 1'b1, 1'b1, 47'd199, 1'b0},
    // one transaction below half the days: best single trade
    '{1'b1, 10'd1,    31'd7,   1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd1,   1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd5,   1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd3,   1'b0, 1'b0, 47'd0, 1'b0},
    '{1'b0, 10'd0,    31'd9,   1'b1, 1'b0, 47'd0, 1'b0}
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [mktx_pkg::K_W-1:0] cfg_wdata_i;

  mktx_in_if  price_ch ();
  mktx_out_if profit_ch ();

  max_profit_k_transactions_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (price_ch),
    .out_o       (profit_ch)
  );

  // Predictor state: one series in flight plus the limit register
  longint                   hold_val [mktx_pkg::MAX_TRANS];
  longint                   sold_val [mktx_pkg::MAX_TRANS];
  longint                   last_price;
  longint                   rise_total;
  longint                   days;
  logic [mktx_pkg::K_W-1:0] limit_now;

  answer_t        answers_due [$];
  bit             typed_due;
  answer_t        typed_answer;

  int unsigned    errors;
  int unsigned    cycles;
  int unsigned    results_seen;
  int unsigned    flags_seen;
  int unsigned    prices_sent;
  bit             quiet;
  bit             hold_request;

  always #5 clk_i = ~clk_i;

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    price_ch.valid    = 1'b0;
    price_ch.price    = '0;
    price_ch.last_day = 1'b0;
    profit_ch.ready   = 1'b1;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic void clear_series();
    for (int j = 0; j < mktx_pkg::MAX_TRANS; j++) begin
      hold_val[j] = FLOOR_VAL;
      sold_val[j] = 0;
    end
    last_price = 0;
    rise_total = 0;
    days       = 0;
  endfunction

  // Apply one day to the per-count DP and the rise sum; answer on the last day
  function automatic bit advance_series(input logic [mktx_pkg::PRICE_W-1:0] price,
                                        input logic last,
                                        output answer_t ans);
    longint pv;
    longint sell;
    longint buy;
    longint prior;
    longint half;
    longint profit;
    pv  = longint'({33'd0, price});
    ans = '0;
    // walk down so each buy sees the previous day's after-sale value
    for (int j = mktx_pkg::MAX_TRANS - 1; j >= 0; j--) begin
      sell  = hold_val[j] + pv;
      prior = (j == 0) ? 0 : sold_val[j-1];
      buy   = prior - pv;
      if (sell > sold_val[j]) begin
        sold_val[j] = (sell > TOP_VAL) ? TOP_VAL : sell;
      end
      if (buy > hold_val[j]) begin
        hold_val[j] = buy;
      end
    end
    if (days != 0 && pv > last_price) begin
      rise_total = rise_total + (pv - last_price);
      if (rise_total > TOP_VAL) begin
        rise_total = TOP_VAL;
      end
    end
    last_price = pv;
    if (days < mktx_pkg::DAY_CAP) begin
      days++;
    end
    if (!last) begin
      return 1'b0;
    end
    half   = days / 2;
    profit = 0;
    if (limit_now == 0) begin
      profit = 0;
    end else if (longint'(limit_now) >= half) begin
      profit = rise_total;
    end else if (limit_now > mktx_pkg::MAX_TRANS) begin
      ans.flag = 1'b1;
    end else begin
      profit = sold_val[int'(limit_now) - 1];
    end
    ans.profit = profit[mktx_pkg::PROFIT_W-1:0];
    clear_series();
    return 1'b1;
  endfunction

  // Watch both channels and the register port; predict and check
  always @(posedge clk_i) begin
    answer_t pred;
    answer_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        limit_now = cfg_wdata_i;
      end
      if (profit_ch.valid && profit_ch.ready) begin
        results_seen++;
        if (profit_ch.limit_exceeded) begin
          flags_seen++;
        end
        if (answers_due.size() == 0) begin
          report_mismatch("result with nothing pending, profit",
                          longint'(profit_ch.best_profit), 0);
        end else begin
          want = answers_due.pop_front();
          if (profit_ch.best_profit !== want.profit) begin
            report_mismatch("best_profit", longint'(profit_ch.best_profit),
                            longint'(want.profit));
          end
          if (profit_ch.limit_exceeded !== want.flag) begin
            report_mismatch("limit_exceeded", longint'(profit_ch.limit_exceeded),
                            longint'(want.flag));
          end
        end
      end
      if (price_ch.valid && price_ch.ready) begin
        if (advance_series(price_ch.price, price_ch.last_day, pred)) begin
          if (typed_due) begin
            answers_due.push_back(typed_answer);
            typed_due = 1'b0;
          end else begin
            answers_due.push_back(pred);
          end
        end
      end
    end
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, answers_due.size());
      $display("[max_profit_k_transactions_unit] ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      profit_ch.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      profit_ch.ready <= 1'b1;
    end else if (!quiet && rst_ni && $urandom_range(0, 9) == 0) begin
      profit_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
      profit_ch.ready <= 1'b1;
    end
  end

  // Offer one price and hold it until the transaction completes
  task automatic send_price(input logic [mktx_pkg::PRICE_W-1:0] price, input logic last,
                            input int gap);
    if (gap > 0) begin
      price_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    price_ch.valid    <= 1'b1;
    price_ch.price    <= price;
    price_ch.last_day <= last;
    do @(posedge clk_i); while (!price_ch.ready);
    prices_sent++;
  endtask

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 7) != 0) begin
      return 0;
    end
    return $urandom_range(1, 19);
  endfunction

  // Stop offering and wait until every pending result has been taken
  task automatic drain_results();
    price_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [mktx_pkg::K_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [mktx_pkg::PRICE_W-1:0] pick_price(
      input int style, input logic [mktx_pkg::PRICE_W-1:0] prev);
    case (style)
      0: return mktx_pkg::PRICE_W'($urandom);
      1: return mktx_pkg::PRICE_W'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return PMAX;
          2: return mktx_pkg::PRICE_W'(1);
          default: return PMAX - 1;
        endcase
      end
      default: return prev + mktx_pkg::PRICE_W'($urandom_range(0, 64))
                      - mktx_pkg::PRICE_W'(32);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned                  random_sent;
    int unsigned                  phase;
    int unsigned                  series_sent;
    int unsigned                  nseries;
    int                           len;
    int                           sel;
    int                           style;
    logic [mktx_pkg::K_W-1:0]     k;
    logic [mktx_pkg::PRICE_W-1:0] price;
    errors       = 0;
    cycles       = 0;
    results_seen = 0;
    flags_seen   = 0;
    prices_sent  = 0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    typed_due    = 1'b0;
    random_sent  = 0;
    series_sent  = 0;
    limit_now    = mktx_pkg::K_RESET;
    clear_series();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].set_k) begin
        write_limit(PLAN[i].k);
      end
      if (PLAN[i].typed) begin
        typed_answer = '{profit: PLAN[i].profit, flag: PLAN[i].flag};
        typed_due    = 1'b1;
      end
      send_price(PLAN[i].price, PLAN[i].last, pick_gap());
      if (PLAN[i].last) begin
        series_sent++;
      end
    end

    // Saw-tooth with a limit above the chain yet below half the days: flagged
    write_limit(WIDE_K);
    for (int d = 0; d < LONG_DAYS; d++) begin
      if (d == LONG_DAYS - 1) begin
        typed_answer = '{profit: '0, flag: 1'b1};
        typed_due    = 1'b1;
      end
      send_price((d % 2 == 0) ? '0 : PMAX, d == LONG_DAYS - 1, 0);
    end
    series_sent++;

    // Random phases: one limit per phase, several well-formed series each
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: k = '0;
        1: k = mktx_pkg::K_W'(1);
        2, 3, 4: k = mktx_pkg::K_W'($urandom_range(2, 16));
        5: k = mktx_pkg::K_W'(mktx_pkg::MAX_TRANS);
        6, 7: k = mktx_pkg::K_W'($urandom_range(17, 40));
        8: k = '1;
        default: k = mktx_pkg::K_W'($urandom_range(0, 1023));
      endcase
      write_limit(k);
      if (phase == 2) begin
        hold_request = 1'b1;
      end
      nseries = $urandom_range(3, 8);
      for (int s = 0; s < nseries; s++) begin
        // sender pause mid-phase until everything is back
        if (phase == 4 && s == 1) begin
          drain_results();
        end
        sel = $urandom_range(0, 9);
        if (sel >= 6 && sel < 8 && k <= 40) begin
          len = 2 * int'(k) + $urandom_range(0, 3) - 1;
        end else if (sel == 8) begin
          len = $urandom_range(13, 60);
        end else if (sel == 9 && k <= 40) begin
          len = 2 * int'(k) + $urandom_range(2, 8);
        end else begin
          len = $urandom_range(1, 12);
        end
        if (len < 1) begin
          len = 1;
        end
        style = $urandom_range(0, 3);
        price = mktx_pkg::PRICE_W'($urandom);
        for (int d = 0; d < len; d++) begin
          price = pick_price(style, price);
          send_price(price, d == len - 1, pick_gap());
          random_sent++;
        end
        series_sent++;
        if (random_sent >= QUIET_FROM) begin
          quiet = 1'b1;
        end
      end
      phase++;
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (answers_due.size() != 0) begin
      report_mismatch("results never delivered", 0, longint'(answers_due.size()));
    end

    $display("covered %0d series over %0d prices in %0d limit phases, incl. over-capacity",
             series_sent, prices_sent, phase);
    $display("checked %0d results, %0d flagged over capacity, %0d mismatches",
             results_seen, flags_seen, errors);
    if (errors == 0) begin
      $display("[max_profit_k_transactions_unit] OK");
    end else begin
      $display("[max_profit_k_transactions_unit] ERROR");
    end
    $finish;
  end

endmodule
